>>> sv/md_pkg.sv
// ----------------------------------------------------------------------------
// md_pkg - shared types and constants for the Mahalanobis distance block
// Fixed-point limits, item codes, sequencer states and the request and
// response groups between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package md_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int CNT_W   = 4;
  localparam int WIDE_W  = 48;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = 48'sh8000_0000_0001;
  localparam logic [WIDE_W-2:0]        MAG_MAX  = {(WIDE_W-1){1'b1}};

  localparam logic [1:0] MODE_COV    = 2'd0;
  localparam logic [1:0] MODE_MEAN   = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_NPD = 2'd1;
  localparam logic [1:0] ST_DIM = 2'd2;

  localparam logic       REG_DIMENSION = 1'b0;
  localparam logic [3:0] DIM_RESET     = 4'd8;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;

  typedef enum logic [1:0] {
    PH_DIAG,
    PH_OFF,
    PH_SOLVE
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_COV_RD,
    S_COV_LD,
    S_K_CHK,
    S_RD_A,
    S_RD_B,
    S_MUL_GO,
    S_MUL_WAIT,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_DIV_PIV,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SQ_GO,
    S_SQ_WAIT,
    S_DIST_GO,
    S_DIST_WAIT,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

>>> sv/mahalanobis_distance_top.sv
// ----------------------------------------------------------------------------
// mahalanobis_distance_top - Cholesky based Mahalanobis distance, Q16.16
// Sequencing: write and non-final sample beats only update the stores; a final
// sample beat with a count mismatch goes straight to the result state; any
// other final beat starts a run of multiplies, divides and roots on the
// shared unit, and the result beat goes out when the run has finished.
// Throughput: one beat per cycle while idle; input held off during a run.
// Reset: synchronous, active high; dimension returns to 8, count to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module mahalanobis_distance_top
  import md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // row[2:0], col[5:3], value[37:6], zero pad
  input  wire logic [1:0]  s_tuser,   // mode[1:0]
  input  wire logic        s_tlast,   // last sample element
  // stream out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // distance[31:0]
  output logic [1:0]       m_tuser,   // status[1:0]
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // --------------------------------------------------------------------------
  // Input beat fields
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]   in_row;
  logic [IDX_W-1:0]   in_col;
  logic signed [31:0] in_value;
  logic               accept;

  assign in_row   = s_tdata[2:0];
  assign in_col   = s_tdata[5:3];
  assign in_value = s_tdata[37:6];
  assign accept   = s_tvalid && s_tready;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t state, state_next;
  phase_t phase;

  logic [3:0]              dimension;
  logic [CNT_W-1:0]        sample_count;
  logic [3:0]              j, i, k;
  logic signed [WIDE_W-1:0] t, piv, opa, q;
  logic [1:0]              status_r;
  logic [31:0]             dist_r;

  logic signed [31:0]       mean_r [MAX_DIM];
  logic signed [32:0]       diff_r [MAX_DIM];
  logic signed [WIDE_W-1:0] y_r    [MAX_DIM];

  // --------------------------------------------------------------------------
  // Derived control values
  // --------------------------------------------------------------------------
  logic [3:0]       n_eff;
  logic [CNT_W-1:0] cnt_inc;
  logic [3:0]       r_sel;
  logic [3:0]       k_lim;
  logic             out_free;
  logic             is_last;
  logic             dim_bad;

  assign n_eff    = (dimension > 4'(MAX_DIM)) ? 4'(MAX_DIM) : dimension;
  assign cnt_inc  = (sample_count < 4'd15) ? sample_count + 1'b1 : sample_count;
  assign r_sel    = (phase == PH_DIAG) ? j : i;
  assign k_lim    = (phase == PH_SOLVE) ? i : j;
  assign out_free = !m_tvalid || m_tready;
  assign is_last  = accept && (s_tuser == MODE_SAMPLE) && s_tlast;
  assign dim_bad  = cnt_inc != n_eff;

  function automatic logic signed [WIDE_W-1:0] clamp49(input logic signed [WIDE_W:0] s);
    if (s > $signed({WIDE_MAX[WIDE_W-1], WIDE_MAX})) begin
      return WIDE_MAX;
    end else if (s < $signed({WIDE_MIN[WIDE_W-1], WIDE_MIN})) begin
      return WIDE_MIN;
    end else begin
      return s[WIDE_W-1:0];
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stores and shared unit
  // --------------------------------------------------------------------------
  logic              cov_we;
  logic [ADDR_W-1:0] cov_raddr;
  logic [31:0]       cov_rdata;
  logic              fac_we;
  logic [ADDR_W-1:0] fac_waddr, fac_raddr;
  logic [WIDE_W-1:0] fac_rdata;

  alu_req_t                 alu_req;
  alu_rsp_t                 alu_rsp;
  logic signed [WIDE_W-1:0] alu_a, alu_b, alu_res;

  md_ram #(.WIDTH(32), .DEPTH(MAX_DIM * MAX_DIM)) u_cov (
    .clk   (clk),
    .we    (cov_we),
    .waddr ({in_row, in_col}),
    .wdata (in_value),
    .raddr (cov_raddr),
    .rdata (cov_rdata)
  );

  md_ram #(.WIDTH(WIDE_W), .DEPTH(MAX_DIM * MAX_DIM)) u_fac (
    .clk   (clk),
    .we    (fac_we),
    .waddr (fac_waddr),
    .wdata (alu_res),
    .raddr (fac_raddr),
    .rdata (fac_rdata)
  );

  md_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (alu_a),
    .b      (alu_b),
    .rsp    (alu_rsp),
    .result (alu_res)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (is_last) begin
          state_next = dim_bad ? S_RESULT : S_COV_RD;
        end
      end
      S_COV_RD: state_next = S_COV_LD;
      S_COV_LD: state_next = S_K_CHK;
      S_K_CHK: begin
        if (k < k_lim) begin
          state_next = S_RD_A;
        end else begin
          case (phase)
            PH_DIAG:  state_next = (t <= 0) ? S_RESULT : S_ROOT_GO;
            PH_OFF:   state_next = S_DIV_GO;
            default:  state_next = S_DIV_PIV;
          endcase
        end
      end
      S_RD_A:     state_next = S_RD_B;
      S_RD_B:     state_next = S_MUL_GO;
      S_MUL_GO:   state_next = S_MUL_WAIT;
      S_MUL_WAIT: if (alu_rsp.done) state_next = S_K_CHK;
      S_ROOT_GO:  state_next = S_ROOT_WAIT;
      S_ROOT_WAIT: begin
        if (alu_rsp.done) begin
          state_next = (j + 1'b1 < n_eff) ? S_COV_RD : S_COV_LD;
        end
      end
      S_DIV_PIV: state_next = S_DIV_GO;
      S_DIV_GO:  state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (alu_rsp.done) begin
          if (phase == PH_SOLVE) begin
            state_next = S_SQ_GO;
          end else if (i + 1'b1 < n_eff || j + 1'b1 < n_eff) begin
            state_next = S_COV_RD;
          end else begin
            state_next = S_COV_LD;
          end
        end
      end
      S_SQ_GO: state_next = S_SQ_WAIT;
      S_SQ_WAIT: begin
        if (alu_rsp.done) begin
          state_next = (i + 1'b1 < n_eff) ? S_COV_LD : S_DIST_GO;
        end
      end
      S_DIST_GO:   state_next = S_DIST_WAIT;
      S_DIST_WAIT: if (alu_rsp.done) state_next = S_RESULT;
      S_RESULT:    if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer: store addresses and shared unit requests
  // --------------------------------------------------------------------------
  always_comb begin
    s_tready      = state == S_IDLE;
    cov_we        = accept && (s_tuser == MODE_COV);
    cov_raddr     = {r_sel[IDX_W-1:0], j[IDX_W-1:0]};
    fac_raddr     = '0;
    fac_we        = 1'b0;
    fac_waddr     = {i[IDX_W-1:0], j[IDX_W-1:0]};
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_a         = opa;
    alu_b         = opa;
    case (state)
      S_RD_A: fac_raddr = {r_sel[IDX_W-1:0], k[IDX_W-1:0]};
      S_RD_B: fac_raddr = {j[IDX_W-1:0], k[IDX_W-1:0]};
      S_DIV_PIV: fac_raddr = {i[IDX_W-1:0], i[IDX_W-1:0]};
      S_MUL_GO: begin
        alu_req.start = 1'b1;
        case (phase)
          PH_OFF:  alu_b = fac_rdata;
          PH_DIAG: alu_b = opa;
          default: alu_b = y_r[k[IDX_W-1:0]];
        endcase
      end
      S_ROOT_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_SQRT;
        alu_a         = t;
      end
      S_ROOT_WAIT: begin
        fac_we    = alu_rsp.done;
        fac_waddr = {j[IDX_W-1:0], j[IDX_W-1:0]};
      end
      S_DIV_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_a         = t;
        alu_b         = (phase == PH_SOLVE) ? fac_rdata : piv;
      end
      S_DIV_WAIT: fac_we = alu_rsp.done && (phase == PH_OFF);
      S_SQ_GO: alu_req.start = 1'b1;
      S_DIST_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_SQRT;
        alu_a         = q;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_DIAG;
      sample_count <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;

      case (state)
        S_IDLE: begin
          if (accept && s_tuser == MODE_MEAN) begin
            mean_r[in_row] <= in_value;
          end
          if (accept && s_tuser == MODE_SAMPLE) begin
            diff_r[in_row] <= {in_value[31], in_value} - {mean_r[in_row][31], mean_r[in_row]};
            sample_count   <= s_tlast ? '0 : cnt_inc;
          end
          if (is_last) begin
            j     <= '0;
            phase <= PH_DIAG;
            if (dim_bad) begin
              status_r <= ST_DIM;
              dist_r   <= '0;
            end
          end
        end
        S_COV_LD: begin
          // solve rows start from the difference, factor rows from the covariance
          t <= (phase == PH_SOLVE) ? {{15{diff_r[i[IDX_W-1:0]][32]}}, diff_r[i[IDX_W-1:0]]}
                                   : {{16{cov_rdata[31]}}, cov_rdata};
          k <= '0;
        end
        S_K_CHK: begin
          if (k >= k_lim && phase == PH_DIAG && t <= 0) begin
            status_r <= ST_NPD;
            dist_r   <= '0;
          end
        end
        S_RD_B: opa <= fac_rdata;
        S_MUL_WAIT: begin
          if (alu_rsp.done) begin
            t <= clamp49({t[WIDE_W-1], t} - {alu_res[WIDE_W-1], alu_res});
            k <= k + 1'b1;
          end
        end
        S_ROOT_WAIT: begin
          if (alu_rsp.done) begin
            piv <= alu_res;
            if (j + 1'b1 < n_eff) begin
              i     <= j + 1'b1;
              phase <= PH_OFF;
            end else begin
              i     <= '0;
              q     <= '0;
              phase <= PH_SOLVE;
            end
          end
        end
        S_DIV_WAIT: begin
          if (alu_rsp.done) begin
            if (phase == PH_SOLVE) begin
              y_r[i[IDX_W-1:0]] <= alu_res;
              opa               <= alu_res;
            end else if (i + 1'b1 < n_eff) begin
              i <= i + 1'b1;
            end else if (j + 1'b1 < n_eff) begin
              j     <= j + 1'b1;
              phase <= PH_DIAG;
            end else begin
              i     <= '0;
              q     <= '0;
              phase <= PH_SOLVE;
            end
          end
        end
        S_SQ_WAIT: begin
          if (alu_rsp.done) begin
            q <= clamp49({q[WIDE_W-1], q} + {alu_res[WIDE_W-1], alu_res});
            if (i + 1'b1 < n_eff) begin
              i <= i + 1'b1;
            end
          end
        end
        S_DIST_WAIT: begin
          if (alu_rsp.done) begin
            dist_r   <= alu_res[31:0];
            status_r <= ST_OK;
          end
        end
        default: begin
        end
      endcase

      // output register: load a finished result, drop a taken beat
      if (state == S_RESULT && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= dist_r;
        m_tuser  <= status_r;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIMENSION) ? {28'b0, dimension} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DIMENSION) begin
      dimension <= pwdata[3:0];
    end
  end

endmodule

`default_nettype wire

>>> sv/md_ram.sv
// ----------------------------------------------------------------------------
// md_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module md_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/md_alu.sv
// ----------------------------------------------------------------------------
// md_alu - shared iterative arithmetic unit
// Q16 multiply (four 24x24 partial products), restoring Q16 divide one
// quotient bit a cycle, and floor square root of (a << 16) two bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module md_alu
  import md_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire alu_req_t                 req,
  input  wire logic signed [WIDE_W-1:0] a,
  input  wire logic signed [WIDE_W-1:0] b,
  output alu_rsp_t                      rsp,
  output logic signed [WIDE_W-1:0]      result
);

  localparam int HALF_W = 24;
  localparam int ACC_W  = 2 * (WIDE_W - 1);

  function automatic logic [WIDE_W-2:0] mag(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-1:0] m;
    m = v[WIDE_W-1] ? (~v + 1'b1) : v;
    return m[WIDE_W-2:0];
  endfunction

  logic                busy;
  logic                done;
  alu_op_t             op_r;
  logic [5:0]          cnt;
  logic                neg;
  logic [WIDE_W-2:0]   opa_m;
  logic [WIDE_W-2:0]   opb_m;
  logic [2*HALF_W-1:0] pp;
  logic [1:0]          pp_code;
  logic [ACC_W-1:0]    acc;
  logic [WIDE_W-1:0]   rem;
  logic [31:0]         root;

  logic [HALF_W-1:0]   a_half, b_half;
  logic [ACC_W-1:0]    pp_shifted;
  logic [ACC_W-17:0]   p16;
  logic [WIDE_W-2:0]   mul_mag;
  logic [WIDE_W-1:0]   div_r2;
  logic                div_ge;
  logic [WIDE_W-2:0]   div_mag;
  logic [34:0]         sq_rem2;
  logic [34:0]         sq_trial;
  logic                sq_ge;

  always_comb begin
    a_half = cnt[0] ? {1'b0, opa_m[WIDE_W-2:HALF_W]} : opa_m[HALF_W-1:0];
    b_half = cnt[1] ? {1'b0, opb_m[WIDE_W-2:HALF_W]} : opb_m[HALF_W-1:0];
    case (pp_code)
      2'd0:    pp_shifted = ACC_W'(pp);
      2'd3:    pp_shifted = ACC_W'(pp) << (2 * HALF_W);
      default: pp_shifted = ACC_W'(pp) << HALF_W;
    endcase
    p16     = acc[ACC_W-1:16];
    mul_mag = (p16 > (ACC_W-16)'(MAG_MAX)) ? MAG_MAX : p16[WIDE_W-2:0];
    div_r2  = {rem[WIDE_W-2:0], acc[62]};
    div_ge  = div_r2 >= {1'b0, opb_m};
    div_mag = (acc[62:0] > 63'(MAG_MAX)) ? MAG_MAX : acc[WIDE_W-2:0];
    sq_rem2  = {rem[32:0], acc[63:62]};
    sq_trial = {1'b0, root, 2'b01};
    sq_ge    = sq_rem2 >= sq_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        op_r <= req.op;
        cnt  <= '0;
        neg  <= a[WIDE_W-1] ^ b[WIDE_W-1];
        case (req.op)
          ALU_MUL: begin
            opa_m <= mag(a);
            opb_m <= mag(b);
            acc   <= '0;
            busy  <= 1'b1;
          end
          ALU_DIV: begin
            if (mag(b) == '0) begin
              result <= a[WIDE_W-1] ? WIDE_MIN : WIDE_MAX;
              done   <= 1'b1;
            end else begin
              opb_m <= mag(b);
              acc   <= {31'b0, mag(a), 16'b0};
              rem   <= '0;
              busy  <= 1'b1;
            end
          end
          ALU_SQRT: begin
            acc  <= {30'b0, 1'b0, a[WIDE_W-2:0], 16'b0};
            rem  <= '0;
            root <= '0;
            busy <= 1'b1;
          end
          default: begin
            done <= 1'b1;
          end
        endcase
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        case (op_r)
          ALU_MUL: begin
            if (cnt <= 6'd3) begin
              pp      <= a_half * b_half;
              pp_code <= cnt[1:0];
            end
            if (cnt >= 6'd1 && cnt <= 6'd4) begin
              acc <= acc + pp_shifted;
            end
            if (cnt == 6'd5) begin
              result <= neg ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});
              done   <= 1'b1;
              busy   <= 1'b0;
            end
          end
          ALU_DIV: begin
            if (cnt == 6'd63) begin
              result <= neg ? -$signed({1'b0, div_mag}) : $signed({1'b0, div_mag});
              done   <= 1'b1;
              busy   <= 1'b0;
            end else begin
              rem       <= div_ge ? (div_r2 - {1'b0, opb_m}) : div_r2;
              acc[62:0] <= {acc[61:0], div_ge};
            end
          end
          ALU_SQRT: begin
            if (cnt == 6'd32) begin
              result <= $signed({16'b0, root});
              done   <= 1'b1;
              busy   <= 1'b0;
            end else begin
              rem       <= {13'b0, sq_ge ? (sq_rem2 - sq_trial) : sq_rem2};
              root      <= {root[30:0], sq_ge};
              acc[63:0] <= {acc[61:0], 2'b00};
            end
          end
          default: begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  assign rsp.done = done;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for mahalanobis_distance_top
// Loads covariance and mean sets, streams sample vectors and checks each
// distance and status beat against a bit-exact fixed-point Cholesky
// predictor, across several dimension settings and handshake pressures.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import md_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int      TOTAL_ITEMS = 1250;
  localparam longint  CYCLE_LIMIT = 3_000_000;
  localparam longint  QMAX        = 64'sh7FFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]  mode;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
  } beat_t;

  typedef struct {
    logic [31:0] distance;
    logic [1:0]  status;
  } dist_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;    // row[2:0], col[5:3], value[37:6], zero pad
  logic [1:0]  s_tuser = '0;    // mode[1:0]
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // distance[31:0]
  logic [1:0]  m_tuser;         // status[1:0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mahalanobis_distance_top u_dut (.*);

  always #2 clk = ~clk;

  // Pending input beats, expected distances, bench knobs.
  beat_t  pending_q[$];
  dist_t  dist_q[$];
  int     errors = 0;
  int     pushed = 0;
  int     send_idle = 10;
  int     recv_idle = 68;
  bit     recv_hold = 1'b0;
  bit     took = 1'b0;
  longint cycles = 0;

  // Predictor state: its own copy of the dimension register and stores.
  logic [3:0] dim_reg = DIM_RESET;
  longint     cov_m[MAX_DIM*MAX_DIM];
  longint     mean_m[MAX_DIM];
  longint     diff_m[MAX_DIM];
  longint     chol_m[MAX_DIM*MAX_DIM];
  int         seen_cnt = 0;

  // Stimulus-side record of the mean, to aim samples near it.
  int mean_set[MAX_DIM];

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic longint unsigned magn(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint sat_sign(input longint unsigned m, input bit neg);
    if (m > QMAX) m = QMAX;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clampq(input longint v);
    if (v > QMAX) return QMAX;
    if (v < -QMAX) return -QMAX;
    return v;
  endfunction

  // Q16 product, split into 24-bit limbs so nothing overflows 64 bits.
  function automatic longint qprod(input longint a, input longint b);
    longint unsigned ua, ub, ah, al, bh, bl, lo, t, t2, r;
    ua = magn(a); ub = magn(b);
    ah = ua >> 24; al = ua & 64'hFF_FFFF;
    bh = ub >> 24; bl = ub & 64'hFF_FFFF;
    lo = al * bl;
    t  = (lo >> 24) + ah * bl + al * bh;
    t2 = (t >> 24) + ah * bh;
    if (t2 >= (64'd1 << 15)) r = QMAX;
    else r = (t2 << 32) + ((t & 64'hFF_FFFF) << 8) + ((lo & 64'hFF_FFFF) >> 16);
    return sat_sign(r, (a < 0) != (b < 0));
  endfunction

  function automatic longint qquot(input longint a, input longint b);
    longint unsigned ub;
    ub = magn(b);
    if (ub == 0) return (a >= 0) ? QMAX : -QMAX;
    return sat_sign((magn(a) << 16) / ub, (a < 0) != (b < 0));
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0; bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Factor, forward-substitute and take the root; returns the status.
  function automatic logic [1:0] cholesky_distance(input int n, output logic [31:0] dval);
    longint y[MAX_DIM];
    longint q, s, t;
    q = 0; dval = '0;
    for (int j = 0; j < n; j++) begin
      s = cov_m[j*MAX_DIM+j];
      for (int k = 0; k < j; k++)
        s = clampq(s - qprod(chol_m[j*MAX_DIM+k], chol_m[j*MAX_DIM+k]));
      if (s <= 0) return ST_NPD;
      chol_m[j*MAX_DIM+j] = longint'(floor_root(longint'(s) << 16));
      for (int i = j + 1; i < n; i++) begin
        t = cov_m[i*MAX_DIM+j];
        for (int k = 0; k < j; k++)
          t = clampq(t - qprod(chol_m[i*MAX_DIM+k], chol_m[j*MAX_DIM+k]));
        chol_m[i*MAX_DIM+j] = qquot(t, chol_m[j*MAX_DIM+j]);
      end
    end
    for (int i = 0; i < n; i++) begin
      t = diff_m[i];
      for (int k = 0; k < i; k++)
        t = clampq(t - qprod(chol_m[i*MAX_DIM+k], y[k]));
      y[i] = qquot(t, chol_m[i*MAX_DIM+i]);
      q = clampq(q + qprod(y[i], y[i]));
    end
    dval = 32'(floor_root(longint'(q) << 16));
    return ST_OK;
  endfunction

  function automatic void predict_beat(input beat_t b);
    longint v;
    int     n;
    dist_t  r;
    v = longint'($signed(b.value));
    case (b.mode)
      MODE_COV:  cov_m[b.row*MAX_DIM+b.col] = v;
      MODE_MEAN: mean_m[b.row] = v;
      MODE_SAMPLE: begin
        diff_m[b.row] = v - mean_m[b.row];
        if (seen_cnt < 15) seen_cnt++;
        if (b.last) begin
          n = (dim_reg > MAX_DIM) ? MAX_DIM : dim_reg;
          if (seen_cnt != n) r.status = ST_DIM;
          else r.status = cholesky_distance(n, r.distance);
          if (r.status != ST_OK) r.distance = '0;
          seen_cnt = 0;
          dist_q.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // Driver: hold a beat until taken, then offer the next or idle.
  always @(posedge clk) took <= s_tvalid && s_tready;

  always @(negedge clk) begin
    beat_t b;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || took) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        b = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, b.value, b.col, b.row};
        s_tuser  <= b.mode;
        s_tlast  <= b.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus the long hold-off.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle);
  end

  // Predict on every accepted input beat.
  always @(posedge clk) begin
    beat_t b;
    if (!rst && s_tvalid && s_tready) begin
      b.row = s_tdata[2:0]; b.col = s_tdata[5:3]; b.value = s_tdata[37:6];
      b.mode = s_tuser; b.last = s_tlast;
      predict_beat(b);
    end
  end

  // Monitor: compare each output beat with the oldest expectation.
  always @(posedge clk) begin
    dist_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (dist_q.size() == 0) begin
        report("unexpected beat", m_tdata, 0);
      end else begin
        w = dist_q.pop_front();
        if (m_tuser !== w.status) report("status", m_tuser, w.status);
        if (m_tdata !== w.distance) report("distance", m_tdata, w.distance);
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Hold off the receiver for a long stretch so the block fills and stalls.
  initial begin
    repeat (4000) @(posedge clk);
    recv_hold = 1'b1;
    repeat (5000) @(posedge clk);
    recv_hold = 1'b0;
  end

  function automatic void push(input logic [1:0] mode, input int row, input int col,
                               input int value, input bit last);
    beat_t b;
    b.mode = mode; b.row = 3'(row); b.col = 3'(col); b.value = value; b.last = last;
    pending_q.push_back(b);
    if (mode == MODE_MEAN) mean_set[row] = value;
    pushed++;
  endfunction

  // Diagonally dominant lower triangle, hence positive definite.
  function automatic void load_spd(input int n);
    int sh;
    sh = ($urandom_range(3) == 0) ? 8 : 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= i; j++)
        if (i == j) push(MODE_COV, i, j,
                         int'((n + 1) * 65536 + $urandom_range(8 * 65536)) >>> sh, 1'b0);
        else push(MODE_COV, i, j, (int'($urandom_range(131072)) - 65536) >>> sh, 1'b0);
  endfunction

  function automatic void load_mean(input int n);
    for (int i = 0; i < n; i++)
      push(MODE_MEAN, i, 0, $urandom_range(8 * 65536) - 4 * 65536, 1'b0);
  endfunction

  // Sample of cnt elements in shuffled order; wild draws full-range values.
  function automatic void send_sample(input int cnt, input bit wild);
    int idx[$];
    int k, tmp, v;
    for (int i = 0; i < cnt; i++) idx.push_back(i % MAX_DIM);
    for (int i = cnt - 1; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = idx[i]; idx[i] = idx[k]; idx[k] = tmp;
    end
    for (int i = 0; i < cnt; i++) begin
      if (wild) v = $urandom();
      else v = mean_set[idx[i]] + $urandom_range(4 * 65536) - 2 * 65536;
      push(MODE_SAMPLE, idx[i], $urandom_range(7), v, i == cnt - 1);
    end
  endfunction

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    dim_reg = data[3:0];
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drain everything in flight, then give the block a short settling pause.
  task automatic drain();
    while (pending_q.size() > 0 || s_tvalid || dist_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int dims[13] = '{8, 1, 0, 15, 3, 2, 5, 8, 4, 9, 1, 6, 7};
    int per_phase, n, pick;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    reg_write({REG_DIMENSION, 2'b00}, 8);

    // Preload every store entry that a later run can read.
    load_spd(MAX_DIM);
    push(MODE_COV, 0, 7, 32'h8000_0000, 1'b0);   // upper triangle, never used
    load_mean(MAX_DIM);
    send_sample(MAX_DIM, 1'b0);

    // Directed corners: extremes, ignored beats, overflow, repeats.
    push(2'd3, 7, 7, 32'hFFFF_FFFF, 1'b1);        // mode three, ignored
    push(MODE_COV, 7, 0, 32'h0000_1000, 1'b1);    // last on a write is ignored
    push(MODE_MEAN, 7, 0, 32'h7FFF_FFFF, 1'b1);
    push(MODE_SAMPLE, 7, 0, 32'h8000_0000, 1'b0); // extreme difference
    send_sample(7, 1'b1);
    for (int i = 0; i < 16; i++) push(MODE_SAMPLE, i % 8, 0, 32'h7FFF_FFFF, i == 15);
    push(MODE_MEAN, 7, 0, 0, 1'b0);
    drain();

    per_phase = (TOTAL_ITEMS - pushed) / $size(dims);
    foreach (dims[p]) begin
      // Idling by thirds: sender light, then receiver light, then none.
      case (p * 3 / $size(dims))
        0: begin send_idle = 10; recv_idle = 68; end
        1: begin send_idle = 68; recv_idle = 10; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      reg_write({REG_DIMENSION, 2'b00}, dims[p]);
      n = (dims[p] > MAX_DIM) ? MAX_DIM : dims[p];
      begin
        int goal;
        goal = pushed + per_phase;
        if (n > 0) begin load_spd(n); load_mean(n); end
        while (pushed < goal) begin
          pick = $urandom_range(99);
          if (n == 0) begin
            send_sample($urandom_range(1, 3), 1'b0);
          end else if (pick < 55) begin
            send_sample(n, $urandom_range(4) == 0);
          end else if (pick < 70) begin
            load_spd(n); load_mean(n); send_sample(n, 1'b0);
          end else if (pick < 80) begin
            send_sample((n == 1) ? 2 : n + ($urandom_range(1) ? 1 : -1), 1'b0);
          end else if (pick < 85) begin
            push(MODE_COV, $urandom_range(n - 1), 0, -$urandom_range(65536), 1'b0);
            send_sample(n, 1'b0);
            load_spd(n);
          end else begin
            // Noise: any mode, any index, any value.
            repeat ($urandom_range(1, 4))
              push(2'($urandom_range(3)), $urandom_range(7), $urandom_range(7),
                   $urandom(), 1'($urandom_range(1)));
          end
        end
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
sv/md_pkg.sv
sv/md_ram.sv
sv/md_alu.sv
sv/mahalanobis_distance_top.sv
tb/testbench.sv
